FILE: rtl/frame_interval_moving_average_defines.svh
// ----------------------------------------------------------------------------
// Frame interval moving average: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRAME_INTERVAL_MOVING_AVERAGE_DEFINES_SVH
`define FRAME_INTERVAL_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define FIMA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define FIMA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define FIMA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define FIMA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/fima_pkg.sv
// ----------------------------------------------------------------------------
// Frame interval moving average: package
// Field widths, register map, reset values and controller states.
// ----------------------------------------------------------------------------
package fima_pkg;

   localparam int unsigned WINDOW_DEFAULT = 50;

   localparam int unsigned STAMP_W    = 64;
   localparam int unsigned AVG_W      = 32;
   localparam int unsigned COUNT_W    = 6;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [AVG_W-1:0] REJECT_LIMIT_RESET = 32'd1000000;

   // word index of a register (byte address bit 2)
   localparam logic REG_REJECT_LIMIT = 1'b0;

   typedef logic [STAMP_W-1:0] stamp_type;
   typedef logic [AVG_W-1:0]   avg_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_UPDATE,
      S_DIVIDE,
      S_DONE
   } state_type;

endpackage

FILE: rtl/fima_if.sv
// ----------------------------------------------------------------------------
// Frame interval moving average: channel interfaces
// Valid/ready channels for timestamp beats and result beats.
// ----------------------------------------------------------------------------
interface fima_req_if;
   logic                valid;
   logic                ready;
   fima_pkg::stamp_type timestamp;

   modport source (output valid, output timestamp, input ready);
   modport sink   (input valid, input timestamp, output ready);
endinterface

interface fima_rsp_if;
   logic                valid;
   logic                ready;
   fima_pkg::avg_type   avg_interval;
   fima_pkg::count_type sample_count;
   logic                accepted;

   modport source (output valid, output avg_interval, output sample_count,
                   output accepted, input ready);
   modport sink   (input valid, input avg_interval, input sample_count,
                   input accepted, output ready);
endinterface

FILE: rtl/frame_interval_moving_average.sv
// ----------------------------------------------------------------------------
// Frame interval moving average
// Windowed mean of frame intervals with outlier rejection.
// ----------------------------------------------------------------------------
// One timestamp beat in, one result beat out. The first beat after reset only
// records the timestamp and returns zeros. Every later beat forms the interval
// to the previous timestamp (modulo 2^64, saturated to 32 bits) and keeps it
// only if it lies closer than reject_limit ticks to the current average; kept
// intervals go into a ring of the last WINDOW intervals held in a single-port
// RAM, and the result carries the truncated mean, the held count and the
// accepted flag. A kept interval passes S_CHECK, S_UPDATE and S_DIVIDE, where
// the bit-serial restoring divider produces one quotient bit per cycle over
// the SUM_W-bit window sum; a rejected interval goes from S_CHECK to S_DONE
// and the priming beat from S_IDLE straight to S_DONE. A new timestamp is
// taken as soon as the controller is idle, even while the previous result
// still waits in the output register. No clearing pass after reset: the held
// count tells which RAM entries are live, so there is no start-up delay.
// reject_limit sits at byte address 0 of the APB-style port (reset 1000000).
// ----------------------------------------------------------------------------
`include "frame_interval_moving_average_defines.svh"

module frame_interval_moving_average #(
   parameter int unsigned WINDOW = fima_pkg::WINDOW_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   fima_req_if.sink                          req_ch,
   fima_rsp_if.source                        rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fima_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fima_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fima_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   import fima_pkg::*;

   localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
   localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned SUM_W  = AVG_W + CNT_W;
   localparam int unsigned STEP_W = $clog2(SUM_W);

   localparam logic [CNT_W-1:0]  WINDOW_CNT = CNT_W'(WINDOW);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW - 1);
   localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(SUM_W - 1);

   // controller
   state_type state_ff, state_in;

   // block state
   logic                primed_ff;
   logic [STAMP_W-1:0]  last_stamp_ff;
   logic [AVG_W-1:0]    limit_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [AVG_W-1:0]    avg_ff;

   // per-beat working registers
   logic [AVG_W-1:0]    interval_ff;
   logic                take_ff;
   logic [SUM_W-1:0]    div_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [SUM_W-1:0]    quo_ff;
   logic [STEP_W-1:0]   step_ff;

   // interval ring
   logic [AVG_W-1:0]    window_mem [WINDOW];
   logic [AVG_W-1:0]    rd_data_ff;

   // output register
   logic                rsp_valid_ff;
   logic [AVG_W-1:0]    rsp_avg_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_acc_ff;

   // datapath
   logic                req_fire;
   logic                csr_write;
   logic [STAMP_W-1:0]  stamp_diff;
   logic [AVG_W-1:0]    interval_sat;
   logic [AVG_W-1:0]    deviation;
   logic                dev_ok;
   logic                window_full;
   logic [AVG_W-1:0]    old_interval;
   logic [SUM_W-1:0]    sum_next;
   logic [CNT_W:0]      trial;
   logic                fits;
   logic [CNT_W-1:0]    rem_next;
   logic                div_last;

   // controller outputs
   logic                req_ready;
   logic                mem_re;
   logic                mem_we;
   logic                rsp_load;

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_W-1] == REG_REJECT_LIMIT);
   assign prdata    = (paddr[CSR_ADDR_W-1] == REG_REJECT_LIMIT) ? limit_ff : '0;

   // ------------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------------
   assign req_fire = req_ch.valid && req_ch.ready;

   // wrap is free: the subtract is modulo 2^64; clamp anything past 32 bits
   assign stamp_diff   = req_ch.timestamp - last_stamp_ff;
   assign interval_sat = (|stamp_diff[STAMP_W-1:AVG_W]) ? '1 : stamp_diff[AVG_W-1:0];

   // outlier test against the average left by the last kept interval
   assign deviation = (interval_ff >= avg_ff) ? (interval_ff - avg_ff)
                                               : (avg_ff - interval_ff);
   assign dev_ok    = deviation < limit_ff;

   // entries beyond the held count are not live and are taken as zero
   assign window_full  = (count_ff == WINDOW_CNT);
   assign old_interval = window_full ? rd_data_ff : '0;
   assign sum_next     = sum_ff - SUM_W'(old_interval) + SUM_W'(interval_ff);

   // restoring divide: shift in one dividend bit, subtract if it fits
   assign trial    = {rem_ff, div_ff[SUM_W-1]};
   assign fits     = trial >= {1'b0, count_ff};
   assign rem_next = fits ? CNT_W'(trial - {1'b0, count_ff}) : CNT_W'(trial);
   assign div_last = (step_ff == LAST_STEP);

   // ------------------------------------------------------------------------
   // Controller: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // priming beat skips straight to the result
               state_in = primed_ff ? S_CHECK : S_DONE;
            end
         end
         S_CHECK: begin
            state_in = dev_ok ? S_UPDATE : S_DONE;
         end
         S_UPDATE: begin
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Controller: outputs
   // ------------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_CHECK: begin
            // fetch the entry the new interval will replace
            mem_re = dev_ok;
         end
         S_UPDATE: begin
            mem_we = 1'b1;
         end
         S_DIVIDE: begin
         end
         S_DONE: begin
            // hand over once the output register is free or draining
            rsp_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
         end
      endcase
   end

   assign req_ch.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // Interval ring RAM: one port, registered read
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[slot_ff] <= interval_ff;
      end
      if (mem_re) begin
         rd_data_ff <= window_mem[slot_ff];
      end
   end

   // ------------------------------------------------------------------------
   // Block state
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff     <= 1'b0;
         last_stamp_ff <= '0;
         limit_ff      <= REJECT_LIMIT_RESET;
         slot_ff       <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
         avg_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            limit_ff <= pwdata;
         end
         if (req_fire) begin
            primed_ff     <= 1'b1;
            last_stamp_ff <= req_ch.timestamp;
         end
         if (state_ff == S_UPDATE) begin
            sum_ff  <= sum_next;
            slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
            if (!window_full) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if ((state_ff == S_DIVIDE) && div_last) begin
            // the quotient never exceeds the largest interval
            avg_ff <= {quo_ff[AVG_W-2:0], fits};
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Working registers and output payload
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               interval_ff <= interval_sat;
               take_ff     <= 1'b0;
            end
         end
         S_CHECK: begin
            take_ff <= dev_ok;
         end
         S_UPDATE: begin
            // load the divider with the new sum
            div_ff  <= sum_next;
            rem_ff  <= '0;
            quo_ff  <= '0;
            step_ff <= '0;
         end
         S_DIVIDE: begin
            div_ff  <= div_ff << 1;
            rem_ff  <= rem_next;
            quo_ff  <= {quo_ff[SUM_W-2:0], fits};
            step_ff <= step_ff + 1'b1;
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_avg_ff   <= avg_ff;
         rsp_count_ff <= COUNT_W'(count_ff);
         rsp_acc_ff   <= take_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.avg_interval = rsp_avg_ff;
   assign rsp_ch.sample_count = rsp_count_ff;
   assign rsp_ch.accepted     = rsp_acc_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // until the ring is full, the write slot tracks the held count
   `FIMA_ASSERT_IMP(a_slot_tracks_count, clock, reset, count_ff != WINDOW_CNT, CNT_W'(slot_ff) == count_ff, "write slot out of step with held count")
   // a kept interval always leaves a nonzero count and a 32-bit quotient
   `FIMA_ASSERT_IMP(a_kept_count, clock, reset, (state_ff == S_DONE) && take_ff, count_ff != '0, "kept interval with empty window")
   `FIMA_ASSERT_IMP(a_quotient_fits, clock, reset, (state_ff == S_DONE) && take_ff, quo_ff[SUM_W-1:AVG_W] == '0, "average overflows 32 bits")
   // a result load always presents a beat in the next cycle
   `FIMA_ASSERT_NXT(a_load_shows, clock, reset, rsp_load, rsp_valid_ff && (state_ff == S_IDLE), "result load lost")

endmodule
